### hw/rtl/hlbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbc_pkg
// Shared constants, codes and types of the hashed LRU buffer cache.
// ----------------------------------------------------------------------------
package hlbc_pkg;

  localparam int NUM_BUFFERS_DEF = 30;
  localparam int NUM_BUCKETS_DEF = 13;

  // fixed field widths
  localparam int MODE_W = 2;
  localparam int DEV_W  = 16;
  localparam int BLK_W  = 32;
  localparam int IDX_W  = 5;
  localparam int STAT_W = 2;
  localparam int REFS_W = 8;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  // request modes
  localparam logic [MODE_W-1:0] MODE_GET     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PIN     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNPIN   = 2'd3;

  // response status
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT,
    S_MOD,
    S_HSTART,
    S_HCHK,
    S_FNEXT,
    S_FCHK,
    S_URD,
    S_UWR,
    S_PRD,
    S_PWR1,
    S_PWR2,
    S_RESP
  } state_t;

endpackage

### hw/rtl/hlbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbc_if
// Request and response channels of the buffer cache (valid/ready beats).
// ----------------------------------------------------------------------------
interface hlbc_req_if;
  logic                            valid;
  logic                            ready;
  logic [hlbc_pkg::MODE_W-1:0]     mode;
  logic [hlbc_pkg::DEV_W-1:0]      device;
  logic [hlbc_pkg::BLK_W-1:0]      block_number;
  logic [hlbc_pkg::IDX_W-1:0]      buffer_index;

  modport source (output valid, mode, device, block_number, buffer_index, input ready);
  modport sink   (input valid, mode, device, block_number, buffer_index, output ready);
endinterface

interface hlbc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [hlbc_pkg::IDX_W-1:0]      buffer_slot;
  logic                            was_hit;
  logic                            needs_disk_read;
  logic [hlbc_pkg::STAT_W-1:0]     status;

  modport source (output valid, buffer_slot, was_hit, needs_disk_read, status, input ready);
  modport sink   (input valid, buffer_slot, was_hit, needs_disk_read, status, output ready);
endinterface

### hw/rtl/hashed_lru_buffer_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_lru_buffer_cache
// Hashed LRU block buffer cache over a fixed pool of buffer slots.
// ----------------------------------------------------------------------------
// Usage: one request beat on req (get, release, pin, unpin) gives exactly one
// response beat on rsp. req.ready is high only while the sequencer is idle;
// one request is in work at a time.
// Sequence: release/pin/unpin check the slot and set the result register; a
// release that drops the count to zero then runs the shared fold and subtract
// mod unit and relinks the slot (URD, UWR, PRD, PWR1, PWR2). A get runs the
// mod unit and starts its walk, then visits the nodes on its bucket list
// (forward, for a hit), then nodes on the backward lists while hunting a free
// slot, and relinks when a slot is stolen from another bucket. Each list walk
// is bounded by the node count.
// The link lists live in two single-port-write memories, one read per cycle,
// which sets the one-node-per-cycle walk rate.
// Reset (synchronous, rst high): all slots empty and unreferenced, all in
// bucket 0 with the last slot most recent; link memories read their reset
// image through per-entry valid bits, so no clearing pass is needed.
// Stall: a finished result sits in the rsp register; the next request may be
// accepted meanwhile, but its own result waits until rsp is taken.
// ----------------------------------------------------------------------------
module hashed_lru_buffer_cache #(
  parameter int NUM_BUFFERS = hlbc_pkg::NUM_BUFFERS_DEF,
  parameter int NUM_BUCKETS = hlbc_pkg::NUM_BUCKETS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  hlbc_req_if.sink          req,
  hlbc_rsp_if.source        rsp
);

  localparam int NODES = NUM_BUFFERS + NUM_BUCKETS;
  localparam int NW    = $clog2(NODES);
  localparam int SW    = $clog2(NUM_BUFFERS);
  localparam int BKW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int KW    = $clog2(NUM_BUCKETS + 1);
  localparam int GW    = $clog2(NODES + 1);
  localparam int IW    = hlbc_pkg::IDX_W;
  // fold width: 2^FOLD_W exceeds the bucket count, and wraps to FOLD_MUL
  localparam int FOLD_W   = BKW + 1;
  localparam int FOLD_MUL = (1 << FOLD_W) % NUM_BUCKETS;

  localparam logic [NW-1:0] HEAD0 = NW'(NUM_BUFFERS);

  // reset image of the link lists
  function automatic logic [NW-1:0] fwd_init(input logic [NW-1:0] a);
    logic [NW-1:0] r;
    if (a < HEAD0) begin
      r = (a == '0) ? HEAD0 : a - NW'(1);
    end else if (a == HEAD0) begin
      r = NW'(NUM_BUFFERS - 1);
    end else begin
      r = a;
    end
    return r;
  endfunction

  function automatic logic [NW-1:0] bwd_init(input logic [NW-1:0] a);
    logic [NW-1:0] r;
    if (a < HEAD0) begin
      r = (a == NW'(NUM_BUFFERS - 1)) ? HEAD0 : a + NW'(1);
    end else if (a == HEAD0) begin
      r = '0;
    end else begin
      r = a;
    end
    return r;
  endfunction

  function automatic logic [NW-1:0] nd(input logic [NW-1:0] a);
    return (32'(a) < NODES) ? a : '0;
  endfunction

  hlbc_pkg::state_t state, state_next;

  // request and work registers
  logic [hlbc_pkg::MODE_W-1:0] mode_r;
  logic [hlbc_pkg::DEV_W-1:0]  dev_r;
  logic [hlbc_pkg::BLK_W-1:0]  blk_r;
  logic [IW-1:0]               idx_r;
  logic [BKW-1:0]              bucket;
  logic [BKW-1:0]              fb;
  logic [hlbc_pkg::BLK_W-1:0]  mod_val;
  logic [NW-1:0]               ln;
  logic [NW-1:0]               first_n;
  logic                        first_pass;
  logic [KW-1:0]               k;
  logic [GW-1:0]               gcnt;

  // result register and output register
  logic [IW-1:0]               res_slot;
  logic                        res_hit;
  logic                        res_rd;
  logic [hlbc_pkg::STAT_W-1:0] res_st;
  logic                        out_valid;
  logic [IW-1:0]               out_slot;
  logic                        out_hit;
  logic                        out_rd;
  logic [hlbc_pkg::STAT_W-1:0] out_st;

  // slot arrays
  logic [hlbc_pkg::DEV_W-1:0]  slot_device [NUM_BUFFERS];
  logic [hlbc_pkg::BLK_W-1:0]  slot_block  [NUM_BUFFERS];
  logic [hlbc_pkg::REFS_W-1:0] slot_refs   [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0]      slot_valid;

  // link memories
  logic [NW-1:0]    fwd_mem [NODES];
  logic [NW-1:0]    bwd_mem [NODES];
  logic [NODES-1:0] fwd_vld;
  logic [NODES-1:0] bwd_vld;
  logic [NW-1:0]    fwd_q, bwd_q;
  logic [NW-1:0]    ra;
  logic             fwd_we, bwd_we;
  logic [NW-1:0]    fwd_wa, fwd_wd, bwd_wa, bwd_wd;
  logic             req_ready;

  // derived values
  logic [NW-1:0]     n_h, n_b, head_b, head_f, node_sel;
  logic [SW-1:0]     sa;
  logic              sa_ok;
  logic [hlbc_pkg::DEV_W-1:0]  s_dev;
  logic [hlbc_pkg::BLK_W-1:0]  s_blk;
  logic [hlbc_pkg::REFS_W-1:0] s_refs;
  logic              s_val;
  logic              idx_ok;
  logic [hlbc_pkg::BLK_W-1:0]  mod_hi;
  logic [hlbc_pkg::BLK_W-1:0]  mod_step;
  logic [BKW-1:0]    rem_next;
  logic              mod_last;
  logic              h_end, h_hit, f_end, f_got;
  logic              fn_fail, fn_go;
  logic [BKW-1:0]    fn_sel;
  logic              rsp_free;

  assign n_h    = nd(fwd_q);
  assign n_b    = nd(bwd_q);
  assign head_b = HEAD0 + NW'(bucket);
  assign head_f = HEAD0 + NW'(fb);
  assign idx_ok = 32'(idx_r) < NUM_BUFFERS;

  // slot read address: list node in the walks, request index otherwise
  always_comb begin
    case (state)
      hlbc_pkg::S_HCHK: node_sel = n_h;
      hlbc_pkg::S_FCHK: node_sel = n_b;
      default:          node_sel = NW'(idx_r);
    endcase
  end
  assign sa_ok  = (32'(node_sel) < NUM_BUFFERS) &&
                  ((state != hlbc_pkg::S_SLOT) || idx_ok);
  assign sa     = sa_ok ? SW'(node_sel) : '0;
  assign s_dev  = slot_device[sa];
  assign s_blk  = slot_block[sa];
  assign s_refs = slot_refs[sa];
  assign s_val  = slot_valid[sa];

  // shared mod unit: fold high bits down by 2^FOLD_W mod N, then subtract N
  assign mod_hi = mod_val >> FOLD_W;
  always_comb begin
    if (mod_hi != '0) begin
      mod_step = {{(hlbc_pkg::BLK_W - FOLD_W){1'b0}}, mod_val[FOLD_W-1:0]} +
                 mod_hi * hlbc_pkg::BLK_W'(FOLD_MUL);
    end else begin
      mod_step = mod_val - hlbc_pkg::BLK_W'(NUM_BUCKETS);
    end
  end
  assign mod_last = (mod_hi == '0) && (mod_val < hlbc_pkg::BLK_W'(NUM_BUCKETS));
  assign rem_next = mod_val[BKW-1:0];

  // list walk decisions
  assign h_end = (n_h == head_b) || (gcnt == GW'(NODES));
  assign h_hit = sa_ok && (s_dev == dev_r) && (s_blk == blk_r);
  assign f_end = (n_b == head_f) || (gcnt == GW'(NODES));
  assign f_got = sa_ok && (s_refs == '0);

  // bucket picker for the free-slot hunt: own bucket first, then index order
  always_comb begin
    fn_fail = 1'b0;
    fn_go   = 1'b0;
    fn_sel  = bucket;
    if (first_pass) begin
      fn_go = 1'b1;
    end else if (k >= KW'(NUM_BUCKETS)) begin
      fn_fail = 1'b1;
    end else if (BKW'(k) != bucket) begin
      fn_go  = 1'b1;
      fn_sel = BKW'(k);
    end
  end

  assign rsp_free = !out_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hlbc_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = (req.mode == hlbc_pkg::MODE_GET) ? hlbc_pkg::S_MOD : hlbc_pkg::S_SLOT;
        end
      end
      hlbc_pkg::S_SLOT: begin
        if (idx_ok && mode_r == hlbc_pkg::MODE_RELEASE && s_refs == hlbc_pkg::REFS_W'(1)) begin
          state_next = hlbc_pkg::S_MOD;
        end else begin
          state_next = hlbc_pkg::S_RESP;
        end
      end
      hlbc_pkg::S_MOD: begin
        if (mod_last) begin
          state_next = (mode_r == hlbc_pkg::MODE_GET) ? hlbc_pkg::S_HSTART : hlbc_pkg::S_URD;
        end
      end
      hlbc_pkg::S_HSTART: state_next = hlbc_pkg::S_HCHK;
      hlbc_pkg::S_HCHK: begin
        if (h_end) begin
          state_next = hlbc_pkg::S_FNEXT;
        end else if (h_hit) begin
          state_next = hlbc_pkg::S_RESP;
        end
      end
      hlbc_pkg::S_FNEXT: begin
        if (fn_fail) begin
          state_next = hlbc_pkg::S_RESP;
        end else if (fn_go) begin
          state_next = hlbc_pkg::S_FCHK;
        end
      end
      hlbc_pkg::S_FCHK: begin
        if (f_end) begin
          state_next = hlbc_pkg::S_FNEXT;
        end else if (f_got) begin
          state_next = (fb != bucket) ? hlbc_pkg::S_URD : hlbc_pkg::S_RESP;
        end
      end
      hlbc_pkg::S_URD:  state_next = hlbc_pkg::S_UWR;
      hlbc_pkg::S_UWR:  state_next = hlbc_pkg::S_PRD;
      hlbc_pkg::S_PRD:  state_next = hlbc_pkg::S_PWR1;
      hlbc_pkg::S_PWR1: state_next = hlbc_pkg::S_PWR2;
      hlbc_pkg::S_PWR2: state_next = hlbc_pkg::S_RESP;
      hlbc_pkg::S_RESP: begin
        if (rsp_free) begin
          state_next = hlbc_pkg::S_IDLE;
        end
      end
      default: state_next = hlbc_pkg::S_IDLE;
    endcase
  end

  // memory port controls and ready
  always_comb begin
    req_ready = 1'b0;
    ra        = head_b;
    fwd_we    = 1'b0;
    fwd_wa    = '0;
    fwd_wd    = '0;
    bwd_we    = 1'b0;
    bwd_wa    = '0;
    bwd_wd    = '0;
    case (state)
      hlbc_pkg::S_IDLE:   req_ready = 1'b1;
      hlbc_pkg::S_HSTART: ra = head_b;
      hlbc_pkg::S_HCHK:   ra = n_h;
      hlbc_pkg::S_FNEXT:  ra = HEAD0 + NW'(fn_sel);
      hlbc_pkg::S_FCHK:   ra = n_b;
      hlbc_pkg::S_URD:    ra = ln;
      hlbc_pkg::S_UWR: begin
        // unlink: back[f] = b, fwd[b] = f
        bwd_we = 1'b1;
        bwd_wa = n_h;
        bwd_wd = n_b;
        fwd_we = 1'b1;
        fwd_wa = n_b;
        fwd_wd = n_h;
      end
      hlbc_pkg::S_PRD:    ra = head_b;
      hlbc_pkg::S_PWR1: begin
        fwd_we = 1'b1;
        fwd_wa = ln;
        fwd_wd = n_h;
        bwd_we = 1'b1;
        bwd_wa = ln;
        bwd_wd = head_b;
      end
      hlbc_pkg::S_PWR2: begin
        bwd_we = 1'b1;
        bwd_wa = first_n;
        bwd_wd = ln;
        fwd_we = 1'b1;
        fwd_wa = head_b;
        fwd_wd = ln;
      end
      default: ;
    endcase
  end

  assign req.ready = req_ready;

  // link memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[fwd_wa] <= fwd_wd;
    end
    if (bwd_we) begin
      bwd_mem[bwd_wa] <= bwd_wd;
    end
    fwd_q <= fwd_vld[ra] ? fwd_mem[ra] : fwd_init(ra);
    bwd_q <= bwd_vld[ra] ? bwd_mem[ra] : bwd_init(ra);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_vld <= '0;
      bwd_vld <= '0;
    end else begin
      if (fwd_we) begin
        fwd_vld[fwd_wa] <= 1'b1;
      end
      if (bwd_we) begin
        bwd_vld[bwd_wa] <= 1'b1;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hlbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath and slot arrays
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        slot_device[i] <= '0;
        slot_block[i]  <= '0;
        slot_refs[i]   <= '0;
      end
      slot_valid <= '0;
    end else begin
      case (state)
        hlbc_pkg::S_IDLE: begin
          if (req.valid) begin
            mode_r   <= req.mode;
            dev_r    <= req.device;
            blk_r    <= req.block_number;
            idx_r    <= req.buffer_index;
            mod_val  <= req.block_number;
            res_slot <= req.buffer_index;
            res_hit  <= 1'b0;
            res_rd   <= 1'b0;
            res_st   <= hlbc_pkg::ST_OK;
          end
        end
        hlbc_pkg::S_SLOT: begin
          if (idx_ok) begin
            if (mode_r == hlbc_pkg::MODE_PIN) begin
              if (s_refs == hlbc_pkg::REFS_MAX) begin
                res_st <= hlbc_pkg::ST_OVERFLOW;
              end else begin
                slot_refs[sa] <= s_refs + hlbc_pkg::REFS_W'(1);
              end
            end else if (s_refs == '0) begin
              res_st <= hlbc_pkg::ST_UNDERFLOW;
            end else begin
              slot_refs[sa] <= s_refs - hlbc_pkg::REFS_W'(1);
            end
          end
          // release to zero: hash the slot's block, then relink it
          mod_val <= s_blk;
          ln      <= NW'(idx_r);
        end
        hlbc_pkg::S_MOD: begin
          if (mod_last) begin
            bucket <= rem_next;
          end else begin
            mod_val <= mod_step;
          end
        end
        hlbc_pkg::S_HSTART: gcnt <= '0;
        hlbc_pkg::S_HCHK: begin
          gcnt <= gcnt + GW'(1);
          if (h_end) begin
            first_pass <= 1'b1;
            k          <= '0;
          end else if (h_hit) begin
            res_slot <= IW'(n_h);
            res_hit  <= 1'b1;
            if (s_refs == hlbc_pkg::REFS_MAX) begin
              res_st <= hlbc_pkg::ST_OVERFLOW;
            end else begin
              slot_refs[sa]  <= s_refs + hlbc_pkg::REFS_W'(1);
              res_rd         <= !s_val;
              slot_valid[sa] <= 1'b1;
            end
          end
        end
        hlbc_pkg::S_FNEXT: begin
          if (fn_fail) begin
            res_slot <= '0;
            res_st   <= hlbc_pkg::ST_NO_FREE;
          end else begin
            if (first_pass) begin
              first_pass <= 1'b0;
            end else begin
              k <= k + KW'(1);
            end
            fb   <= fn_sel;
            gcnt <= '0;
          end
        end
        hlbc_pkg::S_FCHK: begin
          gcnt <= gcnt + GW'(1);
          if (!f_end && f_got) begin
            slot_device[sa] <= dev_r;
            slot_block[sa]  <= blk_r;
            slot_refs[sa]   <= hlbc_pkg::REFS_W'(1);
            slot_valid[sa]  <= 1'b1;
            res_slot        <= IW'(n_b);
            res_rd          <= 1'b1;
            ln              <= n_b;
          end
        end
        hlbc_pkg::S_PWR1: first_n <= n_h;
        default: ;
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == hlbc_pkg::S_RESP && rsp_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hlbc_pkg::S_RESP && rsp_free) begin
      out_slot <= res_slot;
      out_hit  <= res_hit;
      out_rd   <= res_rd;
      out_st   <= res_st;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.buffer_slot     = out_slot;
  assign rsp.was_hit         = out_hit;
  assign rsp.needs_disk_read = out_rd;
  assign rsp.status          = out_st;

  // checks
  a_nofree_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == hlbc_pkg::ST_NO_FREE |->
      rsp.buffer_slot == '0 && !rsp.was_hit && !rsp.needs_disk_read)
    else $error("no-free response carries slot data");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.needs_disk_read |-> rsp.status == hlbc_pkg::ST_OK)
    else $error("disk read flagged on a failed request");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == hlbc_pkg::S_IDLE || state == hlbc_pkg::S_RESP |-> !fwd_we && !bwd_we)
    else $error("link write outside a relink");

  a_guard: assert property (@(posedge clk) disable iff (rst)
    state == hlbc_pkg::S_HCHK || state == hlbc_pkg::S_FCHK |-> gcnt <= GW'(NODES))
    else $error("list walk ran past the node count");

endmodule
